>>> src/cns_pkg.sv
// ----------------------------------------------------------------------------
// cns_pkg
// Shared constants, codes and types of the checksummed parameter store.
// ----------------------------------------------------------------------------
package cns_pkg;

   // Store geometry. The last two bytes hold the checksum pair.
   localparam int DATA_BYTES  = 48;
   localparam int STORE_BYTES = DATA_BYTES + 2;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int BYTE_W      = 8;

   // Fixed port widths.
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;

   // Width that holds both an index and the store size, for the range check.
   localparam int CMP_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESET   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_INVALID = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NODEV = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_CSUM  = 2'd3;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_SWEEP,
      S_RD_IDX,
      S_RD_WAIT,
      S_WR_BYTE,
      S_WR_SWEEP,
      S_WR_DRAIN,
      S_WR_CLO,
      S_WR_CHI,
      S_RESP
   } cns_state_type;

   // Source of a store write.
   typedef enum logic [1:0] {
      WR_REQ,
      WR_CLO,
      WR_CHI
   } cns_wr_sel_type;

   // Source of a result.
   typedef enum logic [1:0] {
      RES_OK,
      RES_NODEV,
      RES_RANGE,
      RES_CHECK
   } cns_res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            latch;
      logic            clear_all;
      logic            sweep_clr;
      logic            cnt_inc;
      logic            rd_en;
      logic            rd_sweep;
      logic            wr_en;
      cns_wr_sel_type  wr_sel;
      logic            res_load;
      cns_res_sel_type res_sel;
      logic            out_load;
   } cns_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic rd_sweep_done;
      logic wr_sweep_done;
   } cns_stat_type;

endpackage

>>> src/cns_ram.sv
// ----------------------------------------------------------------------------
// cns_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cns_datapath.sv
// ----------------------------------------------------------------------------
// cns_datapath
// Byte store, entry valid bits, checksum accumulator and result registers.
// ----------------------------------------------------------------------------
module cns_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cns_pkg::INDEX_W-1:0]     req_index,
   input  logic [cns_pkg::BYTE_W-1:0]      req_write_data,
   input  logic                            req_last_of_request,
   input  cns_pkg::cns_cmd_type            cmd,
   output cns_pkg::cns_stat_type           stat,
   output logic [cns_pkg::BYTE_W-1:0]      rsp_read_data,
   output logic [cns_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int AW = cns_pkg::ADDR_W;
   localparam int BW = cns_pkg::BYTE_W;

   // Latched request.
   logic [cns_pkg::INDEX_W-1:0] idx_ff;
   logic [BW-1:0]               wdata_ff;
   logic                        last_ff;

   // Sweep state.
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] sum_ff, sum_in;
   logic [BW-1:0] cap_lo_ff, cap_hi_ff;

   // Read return tracking.
   logic [AW-1:0] tag_ff;
   logic          sweep_q_ff;
   logic          valid_q_ff;

   // Entry valid bits: an entry not written since reset reads as zero.
   logic [cns_pkg::STORE_BYTES-1:0] valid_ff;

   // Results.
   logic [BW-1:0]                 res_data_ff, res_data_in;
   logic [cns_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [BW-1:0]                 out_data_ff;
   logic [cns_pkg::STATUS_W-1:0]  out_status_ff;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [BW-1:0] wr_data, ram_q, byte_q;
   logic          match;

   assign rd_addr = cmd.rd_sweep ? cnt_ff : AW'(idx_ff);

   always_comb begin
      case (cmd.wr_sel)
         cns_pkg::WR_REQ: begin
            wr_addr = AW'(idx_ff);
            wr_data = wdata_ff;
         end
         cns_pkg::WR_CLO: begin
            wr_addr = AW'(cns_pkg::STORE_BYTES - 2);
            wr_data = ~sum_ff;
         end
         cns_pkg::WR_CHI: begin
            wr_addr = AW'(cns_pkg::STORE_BYTES - 1);
            wr_data = sum_ff;
         end
         default: begin
            wr_addr = AW'(idx_ff);
            wr_data = wdata_ff;
         end
      endcase
   end

   cns_ram #(
      .WIDTH (BW),
      .DEPTH (cns_pkg::STORE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign byte_q = valid_q_ff ? ram_q : '0;

   // Sweep counter and running sum over returned data bytes.
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (cmd.sweep_clr) begin
         cnt_in = '0;
         sum_in = '0;
      end else begin
         if (cmd.cnt_inc) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (sweep_q_ff && (tag_ff < AW'(cns_pkg::DATA_BYTES))) begin
            sum_in = sum_ff + byte_q;
         end
      end
   end

   assign match = (cap_lo_ff == ~sum_ff) && (cap_hi_ff == sum_ff);

   always_comb begin
      case (cmd.res_sel)
         cns_pkg::RES_OK: begin
            res_data_in   = '0;
            res_status_in = cns_pkg::STAT_OK;
         end
         cns_pkg::RES_NODEV: begin
            res_data_in   = '0;
            res_status_in = cns_pkg::STAT_NODEV;
         end
         cns_pkg::RES_RANGE: begin
            res_data_in   = '0;
            res_status_in = cns_pkg::STAT_RANGE;
         end
         cns_pkg::RES_CHECK: begin
            res_data_in   = match ? byte_q : '0;
            res_status_in = match ? cns_pkg::STAT_OK : cns_pkg::STAT_CSUM;
         end
         default: begin
            res_data_in   = '0;
            res_status_in = cns_pkg::STAT_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         sweep_q_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         sweep_q_ff <= cmd.rd_en & cmd.rd_sweep;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         idx_ff   <= req_index;
         wdata_ff <= req_write_data;
         last_ff  <= req_last_of_request;
      end
      cnt_ff <= cnt_in;
      sum_ff <= sum_in;
      if (cmd.rd_en) begin
         tag_ff     <= rd_addr;
         valid_q_ff <= valid_ff[rd_addr];
      end
      if (sweep_q_ff && (tag_ff == AW'(cns_pkg::STORE_BYTES - 2))) begin
         cap_lo_ff <= byte_q;
      end
      if (sweep_q_ff && (tag_ff == AW'(cns_pkg::STORE_BYTES - 1))) begin
         cap_hi_ff <= byte_q;
      end
      if (cmd.res_load) begin
         res_data_ff   <= res_data_in;
         res_status_ff <= res_status_in;
      end
      if (cmd.out_load) begin
         out_data_ff   <= res_data_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign stat.last          = last_ff;
   assign stat.rd_sweep_done = (cnt_ff == AW'(cns_pkg::STORE_BYTES - 1));
   assign stat.wr_sweep_done = (cnt_ff == AW'(cns_pkg::DATA_BYTES - 1));

   assign rsp_read_data = out_data_ff;
   assign rsp_status    = out_status_ff;

endmodule

>>> src/cns_ctrl.sv
// ----------------------------------------------------------------------------
// cns_ctrl
// Controller: decodes each request and sequences the store sweeps.
// ----------------------------------------------------------------------------
module cns_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cns_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cns_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_device_present,
   input  cns_pkg::cns_stat_type         stat,
   output cns_pkg::cns_cmd_type          cmd
);

   cns_pkg::cns_state_type state_ff, state_in;
   logic present_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic range_err;

   assign range_err = (cns_pkg::CMP_W'(req_index) >=
                       cns_pkg::CMP_W'(cns_pkg::STORE_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cns_pkg::S_IDLE;
         present_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            present_ff <= csr_device_present;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.latch     = 1'b0;
      cmd.clear_all = 1'b0;
      cmd.sweep_clr = 1'b0;
      cmd.cnt_inc   = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_sweep  = 1'b0;
      cmd.wr_en     = 1'b0;
      cmd.wr_sel    = cns_pkg::WR_REQ;
      cmd.res_load  = 1'b0;
      cmd.res_sel   = cns_pkg::RES_OK;
      cmd.out_load  = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      case (state_ff)
         cns_pkg::S_IDLE: begin
            req_ready = ~reset;
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (!present_ff) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = cns_pkg::RES_NODEV;
                  state_in     = cns_pkg::S_RESP;
               end else if (req_opcode == cns_pkg::OP_RESET) begin
                  cmd.clear_all = 1'b1;
                  cmd.res_load  = 1'b1;
                  cmd.res_sel   = cns_pkg::RES_OK;
                  state_in      = cns_pkg::S_RESP;
               end else if (range_err || req_opcode == cns_pkg::OP_INVALID) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = cns_pkg::RES_RANGE;
                  state_in     = cns_pkg::S_RESP;
               end else if (req_opcode == cns_pkg::OP_READ) begin
                  cmd.sweep_clr = 1'b1;
                  state_in      = cns_pkg::S_RD_SWEEP;
               end else begin
                  state_in = cns_pkg::S_WR_BYTE;
               end
            end
         end
         cns_pkg::S_RD_SWEEP: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (stat.rd_sweep_done) begin
               state_in = cns_pkg::S_RD_IDX;
            end
         end
         cns_pkg::S_RD_IDX: begin
            cmd.rd_en = 1'b1;
            state_in  = cns_pkg::S_RD_WAIT;
         end
         cns_pkg::S_RD_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = cns_pkg::RES_CHECK;
            state_in     = cns_pkg::S_RESP;
         end
         cns_pkg::S_WR_BYTE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = cns_pkg::WR_REQ;
            if (stat.last) begin
               cmd.sweep_clr = 1'b1;
               state_in      = cns_pkg::S_WR_SWEEP;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = cns_pkg::RES_OK;
               state_in     = cns_pkg::S_RESP;
            end
         end
         cns_pkg::S_WR_SWEEP: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (stat.wr_sweep_done) begin
               state_in = cns_pkg::S_WR_DRAIN;
            end
         end
         cns_pkg::S_WR_DRAIN: begin
            state_in = cns_pkg::S_WR_CLO;
         end
         cns_pkg::S_WR_CLO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = cns_pkg::WR_CLO;
            state_in   = cns_pkg::S_WR_CHI;
         end
         cns_pkg::S_WR_CHI: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = cns_pkg::WR_CHI;
            cmd.res_load = 1'b1;
            cmd.res_sel  = cns_pkg::RES_OK;
            state_in     = cns_pkg::S_RESP;
         end
         cns_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cns_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cns_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = ~reset;

endmodule

>>> src/checksummed_nvram_store.sv
// ----------------------------------------------------------------------------
// checksummed_nvram_store
// Byte-wide parameter store of 50 bytes guarded by an 8-bit checksum pair.
// ----------------------------------------------------------------------------
// The block takes one byte access per request beat and returns one response
// beat per request. Bytes 0 to 47 are data, byte 48 holds the complement of
// the 8-bit sum of the data bytes and byte 49 holds the sum itself. A read
// first sweeps the whole store through the single read port of the byte RAM,
// one byte per cycle, to recompute the sum and fetch the stored pair, then
// reads the addressed byte. A write marked last also sweeps the 48 data bytes
// and writes the checksum pair back. Reset-all, range errors, invalid
// opcodes and accesses with the device absent are answered without a sweep.
// One request is worked on at a time; a finished response sits in an output
// register, and the next request is accepted while it waits to be taken.
// After reset every byte reads as zero (per-entry valid bits, no clearing
// pass), so reads report a checksum error until a write marked last. The
// device_present register is written through the csr port, which is ready
// whenever reset is low, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module checksummed_nvram_store (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cns_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cns_pkg::INDEX_W-1:0]   req_index,
   input  logic [cns_pkg::BYTE_W-1:0]    req_write_data,
   input  logic                          req_last_of_request,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cns_pkg::BYTE_W-1:0]    rsp_read_data,
   output logic [cns_pkg::STATUS_W-1:0]  rsp_status,
   // Configuration write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_device_present
);

   cns_pkg::cns_cmd_type  cmd;
   cns_pkg::cns_stat_type stat;

   // The controller decodes each request beat and steps the datapath through
   // the checksum sweep and the byte access.
   cns_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_index          (req_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_device_present (csr_device_present),
      .stat               (stat),
      .cmd                (cmd)
   );

   // The datapath holds the byte RAM, its valid bits, the running sum and
   // the response registers.
   cns_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_index           (req_index),
      .req_write_data      (req_write_data),
      .req_last_of_request (req_last_of_request),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_read_data       (rsp_read_data),
      .rsp_status          (rsp_status)
   );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the checksummed parameter store.
// ----------------------------------------------------------------------------
// A table of directed accesses comes first. It covers the cleared store after
// reset, the index extremes, every opcode, writes at the checksum position,
// and accesses while the device is absent. About two thousand random accesses
// follow, mostly well-formed reads and writes. A shadow copy of the store
// predicts every response beat, and the beats are compared in order. Request
// gaps and response stalls come in random lengths, with full-rate stretches
// in between.
// ----------------------------------------------------------------------------
module tb;

   // One request beat, and one response beat.
   typedef struct packed {
      logic [cns_pkg::OPCODE_W-1:0] op;
      logic [cns_pkg::INDEX_W-1:0]  idx;
      logic [cns_pkg::BYTE_W-1:0]   wdata;
      logic                         last;
   } access_type;

   typedef struct packed {
      logic [cns_pkg::BYTE_W-1:0]   data;
      logic [cns_pkg::STATUS_W-1:0] status;
   } reply_type;

   // One row of the directed table. A row either writes device_present or
   // sends an access. An access row with fixed set carries its expected
   // response. Every other row is checked against the shadow store.
   typedef struct packed {
      logic       cfg;
      logic       cfg_val;
      access_type acc;
      logic       fixed;
      reply_type  want;
   } step_type;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RANDOM_PHASES = 8;

   // DUT inputs are known from time zero.
   logic                         clock               = 1'b0;
   logic                         reset               = 1'b1;
   logic                         req_valid           = 1'b0;
   logic [cns_pkg::OPCODE_W-1:0] req_opcode          = '0;
   logic [cns_pkg::INDEX_W-1:0]  req_index           = '0;
   logic [cns_pkg::BYTE_W-1:0]   req_write_data      = '0;
   logic                         req_last_of_request = 1'b0;
   logic                         rsp_ready           = 1'b0;
   logic                         csr_valid           = 1'b0;
   logic                         csr_device_present  = 1'b1;

   logic                         req_ready;
   logic                         rsp_valid;
   logic [cns_pkg::BYTE_W-1:0]   rsp_read_data;
   logic [cns_pkg::STATUS_W-1:0] rsp_status;
   logic                         csr_ready;

   // Shadow state of the store, updated at each accepted beat.
   logic [cns_pkg::BYTE_W-1:0] shadow_bytes [cns_pkg::STORE_BYTES];
   logic                       shadow_present;
   reply_type                  pending_replies [$];

   // The expected response typed into a directed row travels alongside the
   // request payload, so it is stable for as long as the beat is offered.
   logic      fix_en  = 1'b0;
   reply_type fix_val = '0;

   // Idling controls. The request gap odds belong to the driver process, the
   // stall odds are read by the response side and so are changed only by
   // nonblocking assignment.
   int gap_pct    = 30;
   int stall_pct  = 25;
   int stall_left = 0;

   int errors  = 0;
   int n_csr   = 0;
   int n_beats = 0;
   int n_stat [4] = '{0, 0, 0, 0};

   reply_type predicted;
   reply_type oldest;
   step_type  script [$];

   checksummed_nvram_store u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_index           (req_index),
      .req_write_data      (req_write_data),
      .req_last_of_request (req_last_of_request),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_device_present  (csr_device_present)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Ends the run if the traffic stalls for good. The slowest correct run,
   // with every gap and stall at its longest, stays well under a fifth of it.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Gap lengths: drawn mostly from the shortest range, sometimes from the middle one, rarely from the longest.
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // 8-bit sum of the data bytes in the shadow store.
   function automatic logic [cns_pkg::BYTE_W-1:0] shadow_sum();
      logic [cns_pkg::BYTE_W-1:0] s;
      s = '0;
      for (int i = 0; i < cns_pkg::DATA_BYTES; i++)
         s = s + shadow_bytes[i];
      return s;
   endfunction

   // Applies one access to the shadow store and returns the response that
   // the block has to give for it.
   function automatic reply_type store_access(access_type a);
      reply_type                  r;
      logic [cns_pkg::BYTE_W-1:0] s;
      r = '{data: '0, status: cns_pkg::STAT_OK};
      if (!shadow_present) begin
         r.status = cns_pkg::STAT_NODEV;
      end else if (a.op == cns_pkg::OP_RESET) begin
         // Reset-all ignores the index and clears the checksum pair as well.
         for (int i = 0; i < cns_pkg::STORE_BYTES; i++)
            shadow_bytes[i] = '0;
      end else if (a.op == cns_pkg::OP_INVALID || a.idx > cns_pkg::STORE_BYTES - 2) begin
         r.status = cns_pkg::STAT_RANGE;
      end else if (a.op == cns_pkg::OP_READ) begin
         s = shadow_sum();
         if (shadow_bytes[cns_pkg::STORE_BYTES-2] != ~s ||
             shadow_bytes[cns_pkg::STORE_BYTES-1] != s)
            r.status = cns_pkg::STAT_CSUM;
         else
            r.data = shadow_bytes[a.idx];
      end else begin
         // The complement byte is a legal write target and gets overwritten.
         shadow_bytes[a.idx] = a.wdata;
         if (a.last) begin
            s = shadow_sum();
            shadow_bytes[cns_pkg::STORE_BYTES-2] = ~s;
            shadow_bytes[cns_pkg::STORE_BYTES-1] = s;
         end
      end
      return r;
   endfunction

   // Row builders for the directed table.
   function automatic step_type acc_row(logic [cns_pkg::OPCODE_W-1:0] op, int idx,
                                        logic [cns_pkg::BYTE_W-1:0] wd, logic last);
      step_type t;
      t     = '0;
      t.acc = '{op: op, idx: idx[cns_pkg::INDEX_W-1:0], wdata: wd, last: last};
      return t;
   endfunction

   function automatic step_type known_row(logic [cns_pkg::OPCODE_W-1:0] op, int idx,
                                          logic [cns_pkg::BYTE_W-1:0] wd, logic last,
                                          logic [cns_pkg::STATUS_W-1:0] st);
      step_type t;
      t       = acc_row(op, idx, wd, last);
      t.fixed = 1'b1;
      t.want  = '{data: '0, status: st};
      return t;
   endfunction

   function automatic step_type csr_row(logic v);
      step_type t;
      t         = '0;
      t.cfg     = 1'b1;
      t.cfg_val = v;
      return t;
   endfunction

   // Offers one request beat, after an optional gap, and returns at the edge
   // where it is accepted. With no gap the valid simply stays high and only
   // the payload moves on.
   task automatic send_access(access_type a, logic fixed, reply_type want);
      int gap;
      gap = ($urandom_range(99) < gap_pct) ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode          <= a.op;
      req_index           <= a.idx;
      req_write_data      <= a.wdata;
      req_last_of_request <= a.last;
      fix_en              <= fixed;
      fix_val             <= want;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drops the request valid and waits until every response beat is back,
   // plus SETTLE_CYCLES so that the block is surely idle. It first waits for
   // the next clock edge so that the monitor has logged the beat accepted last.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_present(logic v);
      csr_device_present <= v;
      csr_valid          <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: ready drops for random stretches while stall_pct is set.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= gap_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor and scoreboard. All sampling happens at the rising edge, on the
   // values that held just before it. The response beat is retired before a
   // new request is predicted, since a beat accepted at this edge cannot be
   // answered at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cns_pkg::STORE_BYTES; i++)
            shadow_bytes[i] = '0;
         shadow_present = 1'b1;
         pending_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               $error("response beat with nothing outstanding: read_data %02h status %0d",
                      rsp_read_data, rsp_status);
               errors++;
            end else begin
               oldest = pending_replies.pop_front();
               if (rsp_read_data !== oldest.data) begin
                  $error("read_data: expected %02h, got %02h", oldest.data, rsp_read_data);
                  errors++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  errors++;
               end
            end
            if (!$isunknown(rsp_status))
               n_stat[rsp_status]++;
         end
         if (req_valid && req_ready) begin
            predicted = store_access('{op: req_opcode, idx: req_index,
                                       wdata: req_write_data,
                                       last: req_last_of_request});
            // A directed row with a typed expectation is held to that value;
            // the shadow store is still updated so that later rows stay right.
            pending_replies.push_back(fix_en ? fix_val : predicted);
            n_beats++;
         end
         if (csr_valid && csr_ready) begin
            shadow_present = csr_device_present;
            n_csr++;
         end
      end
   end

   // Stimulus.
   initial begin
      access_type a;
      int         r;
      int         n;
      logic       busy;

      script = '{
         // A cleared store fails the checksum on any read.
         known_row(cns_pkg::OP_READ,    0,  8'h00, 1'b0, cns_pkg::STAT_CSUM),
         // A write without the last mark leaves the pair stale.
         acc_row  (cns_pkg::OP_WRITE,   0,  8'hFF, 1'b0),
         acc_row  (cns_pkg::OP_READ,    0,  8'h00, 1'b0),
         // The last mark seals the pair; reads then return data.
         acc_row  (cns_pkg::OP_WRITE,   47, 8'h01, 1'b1),
         acc_row  (cns_pkg::OP_READ,    0,  8'h00, 1'b0),
         acc_row  (cns_pkg::OP_READ,    47, 8'h00, 1'b0),
         acc_row  (cns_pkg::OP_READ,    48, 8'h00, 1'b0),
         // Index and opcode errors.
         known_row(cns_pkg::OP_READ,    49, 8'h00, 1'b0, cns_pkg::STAT_RANGE),
         known_row(cns_pkg::OP_READ,    63, 8'h00, 1'b0, cns_pkg::STAT_RANGE),
         known_row(cns_pkg::OP_WRITE,   49, 8'hAA, 1'b1, cns_pkg::STAT_RANGE),
         known_row(cns_pkg::OP_INVALID, 0,  8'h55, 1'b1, cns_pkg::STAT_RANGE),
         known_row(cns_pkg::OP_INVALID, 63, 8'h00, 1'b0, cns_pkg::STAT_RANGE),
         // Writing the complement byte breaks the pair until a last write.
         acc_row  (cns_pkg::OP_WRITE,   48, 8'h00, 1'b0),
         acc_row  (cns_pkg::OP_READ,    5,  8'h00, 1'b0),
         acc_row  (cns_pkg::OP_WRITE,   48, 8'h5A, 1'b1),
         acc_row  (cns_pkg::OP_READ,    48, 8'h00, 1'b0),
         acc_row  (cns_pkg::OP_WRITE,   2,  8'h33, 1'b1),
         // With the device absent nothing may change.
         csr_row  (1'b0),
         known_row(cns_pkg::OP_WRITE,   2,  8'h44, 1'b1, cns_pkg::STAT_NODEV),
         known_row(cns_pkg::OP_RESET,   0,  8'h00, 1'b0, cns_pkg::STAT_NODEV),
         known_row(cns_pkg::OP_READ,    63, 8'h00, 1'b0, cns_pkg::STAT_NODEV),
         csr_row  (1'b1),
         acc_row  (cns_pkg::OP_READ,    2,  8'h00, 1'b0),
         // Reset-all works at any index and leaves a failing checksum.
         known_row(cns_pkg::OP_RESET,   63, 8'h00, 1'b0, cns_pkg::STAT_OK),
         known_row(cns_pkg::OP_READ,    2,  8'h00, 1'b0, cns_pkg::STAT_CSUM),
         known_row(cns_pkg::OP_RESET,   0,  8'hFF, 1'b1, cns_pkg::STAT_OK)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k]) begin
         if (script[k].cfg) begin
            wait_idle();
            write_present(script[k].cfg_val);
         end else begin
            send_access(script[k].acc, script[k].fixed, script[k].want);
         end
      end

      // Random phases. Every third phase runs at full rate on both sides.
      // One short phase runs with the device absent.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         write_present(ph != 5);
         busy      = (ph % 3 == 2);
         gap_pct   = busy ? 0 : 30;
         stall_pct <= busy ? 0 : 25;
         n         = (ph == 5) ? 40 : 280;
         repeat (n) begin
            r       = $urandom_range(99);
            a.wdata = cns_pkg::BYTE_W'($urandom_range(255));
            a.last  = 1'($urandom_range(1));
            // In-range indices lean toward the ends of the data area and
            // the complement byte.
            case ($urandom_range(9))
               0:       a.idx = '0;
               1:       a.idx = cns_pkg::INDEX_W'(cns_pkg::STORE_BYTES - 2);
               2:       a.idx = cns_pkg::INDEX_W'(cns_pkg::DATA_BYTES - 1);
               default: a.idx = cns_pkg::INDEX_W'($urandom_range(cns_pkg::STORE_BYTES - 2));
            endcase
            if (r < 45) begin
               a.op = cns_pkg::OP_READ;
            end else if (r < 65) begin
               a.op   = cns_pkg::OP_WRITE;
               a.last = 1'b1;
            end else if (r < 83) begin
               a.op   = cns_pkg::OP_WRITE;
               a.last = 1'b0;
            end else if (r < 89) begin
               a.op  = $urandom_range(1) ? cns_pkg::OP_WRITE : cns_pkg::OP_READ;
               a.idx = cns_pkg::INDEX_W'($urandom_range(63, cns_pkg::STORE_BYTES - 1));
            end else if (r < 94) begin
               a.op  = cns_pkg::OP_INVALID;
               a.idx = cns_pkg::INDEX_W'($urandom_range(63));
            end else if (r < 96) begin
               a.op  = cns_pkg::OP_RESET;
               a.idx = cns_pkg::INDEX_W'($urandom_range(63));
            end else begin
               a.op  = cns_pkg::OPCODE_W'($urandom_range(3));
               a.idx = cns_pkg::INDEX_W'($urandom_range(63));
            end
            send_access(a, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d access beats checked: %0d ok, %0d no-device, %0d range,",
               n_beats, n_stat[cns_pkg::STAT_OK], n_stat[cns_pkg::STAT_NODEV],
               n_stat[cns_pkg::STAT_RANGE]);
      $display("Summary: %0d checksum, %0d device_present writes, stalls on both sides",
               n_stat[cns_pkg::STAT_CSUM], n_csr);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
src/cns_pkg.sv
src/cns_ram.sv
src/cns_datapath.sv
src/cns_ctrl.sv
src/checksummed_nvram_store.sv
verif/tb.sv
